/* hdl/wprm_pkg.sv */
// Shared types and constants of the record-to-markup converter.
// Depends on nothing.
package wprm_pkg;

	localparam logic [3:0] TK_START   = 4'd0;
	localparam logic [3:0] TK_END     = 4'd1;
	localparam logic [3:0] TK_CHAR    = 4'd2;
	localparam logic [3:0] TK_SPACES  = 4'd3;
	localparam logic [3:0] TK_NEWLINE = 4'd4;
	localparam logic [3:0] TK_OPEN    = 4'd5;
	localparam logic [3:0] TK_CLOSE   = 4'd6;
	localparam logic [3:0] TK_ENTITY  = 4'd7;
	localparam logic [3:0] TK_ERROR   = 4'd8;

	localparam logic [1:0] STY_BOLD  = 2'd0;
	localparam logic [1:0] STY_SUP   = 2'd1;
	localparam logic [1:0] STY_SUB   = 2'd2;
	localparam logic [1:0] STY_UNDER = 2'd3;

	localparam logic [7:0] ENT_NBSP = 8'd0;
	localparam logic [7:0] ENT_AMP  = 8'd1;
	localparam logic [7:0] ENT_LT   = 8'd2;
	localparam logic [7:0] ENT_GT   = 8'd3;

	localparam logic [7:0] ERR_SIGNATURE = 8'd1;
	localparam logic [7:0] ERR_HEADER    = 8'd2;
	localparam logic [7:0] ERR_LINE      = 8'd3;

	localparam logic [8:0] SIG_POS       = 9'd4;
	localparam logic [7:0] SIG_VALUE     = 8'd79;
	localparam logic [7:0] REC_LINE      = 8'h00;
	localparam logic [7:0] REC_SPACES    = 8'hd0;
	localparam logic [7:0] CH_STICKY     = 8'd11;
	localparam logic [7:0] CH_TAB_A      = 8'h16;
	localparam logic [7:0] CH_TAB_B      = 8'h17;
	localparam logic [7:0] CH_PRINT      = 8'd32;
	localparam logic [7:0] CH_STYLE_LAST = 8'd8;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_LT         = 8'h3c;
	localparam logic [7:0] CH_GT         = 8'h3e;

	// pending-token bits, in emit order
	localparam int PB_START = 0;
	localparam int PB_MAIN  = 1;
	localparam int PB_NL    = 2;
	localparam int PB_BOLD  = 3;
	localparam int PB_UNDER = 4;
	localparam int PB_SUP   = 5;
	localparam int PB_SUB   = 6;
	localparam int PB_COUNT = 7;

	typedef struct packed {
		logic [PB_COUNT-1:0] pend;
		logic [3:0]          kind;
		logic [7:0]          value;
	} desc_t;

endpackage

/* hdl/wprm_if.sv */
// Handshake channels of the converter: file words in, markup tokens out.
// Depends on nothing.
interface wprm_byte_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;
	modport source(output valid, command, data_byte, input ready);
	modport sink(input valid, command, data_byte, output ready);
endinterface

interface wprm_tok_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] token_value;
	logic       last_token;
	modport source(output valid, token_kind, token_value, last_token, input ready);
	modport sink(input valid, token_kind, token_value, last_token, output ready);
endinterface

/* hdl/word_processor_record_to_markup_unit.sv */
// Top level of the record-to-markup converter.
// Depends on wprm_pkg, wprm_if, wprm_front, wprm_queue and wprm_back.
//
// file_bytes carries one file word per handshake: command 0 with a data
// byte, or command 1 for end of file. tokens carries markup tokens, each
// with last_token set on the final token caused by a given file word.
// The front end parses a word in the cycle it is accepted and writes one
// descriptor (up to six tokens) into a QUEUE_DEPTH-entry queue; words that
// cause no token write nothing. The back end emits one token per cycle,
// while the receiver is ready, into an output register, so the first token
// of a word passes through its queue entry and then the output register.
// file_bytes takes one word per cycle while the queue has room; sustained
// throughput is set by the back end's one token per cycle, and bursts of
// several tokens per word are absorbed by the queue.
// When the receiver stalls, the output register holds its token and the
// queue fills; file_bytes.ready drops once the queue is full.
// Reset clears the parser to the header phase with all styles off and
// empties the queue and output register.
module word_processor_record_to_markup_unit import wprm_pkg::*; #(
	parameter int HEADER_BYTES = 300,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	wprm_byte_if.sink  file_bytes,
	wprm_tok_if.source tokens
);

	desc_t desc, head;
	logic  push, full, empty, pop, accept;

	assign file_bytes.ready = !full;
	assign accept = file_bytes.valid && !full;

	wprm_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (file_bytes.command),
		.data_byte (file_bytes.data_byte),
		.push      (push),
		.desc      (desc)
	);

	wprm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (desc),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	wprm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

/* hdl/wprm_front.sv */
// Front end: parses each file word and builds one token descriptor per word.
// Depends on wprm_pkg.
module wprm_front import wprm_pkg::*; #(
	parameter int HEADER_BYTES = 300
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        push,
	output desc_t       desc
);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_LEN    = 5'b00010,
		PH_TYPE   = 5'b00100,
		PH_BODY   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [8:0] hpos_q, hpos_n;
	logic [7:0] len_q, len_n;
	logic [7:0] idx_q, idx_n;
	logic [6:0] tlen_q, tlen_n;
	logic       ret_q, ret_n;
	logic [3:0] flags_q, flags_n;
	logic       started_q;

	always_comb begin
		logic [3:0] cm1;
		logic [1:0] sty;
		logic       ret_eff;
		desc = '0;
		phase_n = phase_q;
		hpos_n = hpos_q;
		len_n = len_q;
		idx_n = idx_q;
		tlen_n = tlen_q;
		ret_n = ret_q;
		flags_n = flags_q;
		cm1 = data_byte[3:0] - 4'd1;
		sty = cm1[2:1];
		ret_eff = ret_q;
		if (!started_q) begin
			desc.pend[PB_START] = 1'b1;
		end
		if (phase_q != PH_DONE) begin
			if (command) begin
				desc.pend[PB_MAIN] = 1'b1;
				if (phase_q == PH_HEADER) begin
					desc.kind = TK_ERROR;
					desc.value = ERR_HEADER;
				end else if (phase_q == PH_BODY) begin
					desc.kind = TK_ERROR;
					desc.value = ERR_LINE;
				end else begin
					desc.kind = TK_END;
				end
				phase_n = PH_DONE;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (hpos_q == SIG_POS && data_byte != SIG_VALUE) begin
							desc.pend[PB_MAIN] = 1'b1;
							desc.kind = TK_ERROR;
							desc.value = ERR_SIGNATURE;
							phase_n = PH_DONE;
						end else begin
							hpos_n = hpos_q + 9'd1;
							if (hpos_n >= 9'(HEADER_BYTES)) begin
								phase_n = PH_LEN;
							end
						end
					end
					PH_LEN: begin
						len_n = data_byte;
						phase_n = PH_TYPE;
					end
					PH_TYPE: begin
						phase_n = PH_LEN;
						if (data_byte == REC_LINE) begin
							idx_n = '0;
							tlen_n = '0;
							ret_n = 1'b0;
							if (len_q == 8'd0) begin
								desc.pend[PB_NL] = 1'b1;
							end else begin
								phase_n = PH_BODY;
							end
						end else if (data_byte == REC_SPACES) begin
							desc.pend[PB_MAIN] = (len_q != 8'd0);
							desc.kind = TK_SPACES;
							desc.value = len_q;
							desc.pend[PB_NL] = 1'b1;
							desc.pend[PB_BOLD] = flags_q[STY_BOLD];
							desc.pend[PB_UNDER] = flags_q[STY_UNDER];
							desc.pend[PB_SUP] = flags_q[STY_SUP];
							desc.pend[PB_SUB] = flags_q[STY_SUB];
							flags_n = '0;
						end
					end
					PH_BODY: begin
						if (idx_q == 8'd0) begin
							desc.pend[PB_MAIN] = (data_byte[6:0] != 7'd0);
							desc.kind = TK_SPACES;
							desc.value = {1'b0, data_byte[6:0]};
						end else if (idx_q == 8'd1) begin
							tlen_n = data_byte[6:0];
							ret_n = data_byte[7];
							ret_eff = data_byte[7];
						end else if ((idx_q - 8'd2) < {1'b0, tlen_q}) begin
							if (data_byte != 8'd0 && data_byte <= CH_STYLE_LAST) begin
								desc.kind = data_byte[0] ? TK_OPEN : TK_CLOSE;
								desc.value = {6'd0, sty};
								if (data_byte[0] != flags_q[sty]) begin
									desc.pend[PB_MAIN] = 1'b1;
									flags_n[sty] = data_byte[0];
								end
							end else if (data_byte == CH_STICKY || data_byte == CH_TAB_A
									|| data_byte == CH_TAB_B) begin
								desc.pend[PB_MAIN] = 1'b1;
								desc.kind = TK_ENTITY;
								desc.value = ENT_NBSP;
							end else if (data_byte >= CH_PRINT) begin
								desc.pend[PB_MAIN] = 1'b1;
								desc.kind = TK_ENTITY;
								if (data_byte == CH_AMP) begin
									desc.value = ENT_AMP;
								end else if (data_byte == CH_LT) begin
									desc.value = ENT_LT;
								end else if (data_byte == CH_GT) begin
									desc.value = ENT_GT;
								end else begin
									desc.kind = TK_CHAR;
									desc.value = data_byte;
								end
							end
						end
						idx_n = idx_q + 8'd1;
						if (idx_n >= len_q) begin
							desc.pend[PB_NL] = 1'b1;
							phase_n = PH_LEN;
							if (ret_eff) begin
								desc.pend[PB_BOLD] = flags_n[STY_BOLD];
								desc.pend[PB_UNDER] = flags_n[STY_UNDER];
								desc.pend[PB_SUP] = flags_n[STY_SUP];
								desc.pend[PB_SUB] = flags_n[STY_SUB];
								flags_n = '0;
							end
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	assign push = accept && (desc.pend != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			tlen_q <= '0;
			ret_q <= 1'b0;
			flags_q <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			hpos_q <= hpos_n;
			len_q <= len_n;
			idx_q <= idx_n;
			tlen_q <= tlen_n;
			ret_q <= ret_n;
			flags_q <= flags_n;
			started_q <= 1'b1;
		end
	end

endmodule

/* hdl/wprm_queue.sv */
// Descriptor queue between the parsing front end and the token back end.
// Depends on wprm_pkg.
module wprm_queue import wprm_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output desc_t head,
	output logic  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         entry_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hdl/wprm_back.sv */
// Back end: expands descriptors into one token word per cycle while the receiver is ready.
// Depends on wprm_pkg and wprm_if.
module wprm_back import wprm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  desc_t         head,
	input  logic          empty,
	output logic          pop,
	wprm_tok_if.source    tokens
);

	logic [PB_COUNT-1:0] pend_q, sel, pick, rem;
	logic [3:0]          kind_q, kind_sel, tk_kind;
	logic [7:0]          value_q, value_sel, tk_value;
	logic                valid_q, advance;
	logic [3:0]          tkind_q;
	logic [7:0]          tvalue_q;
	logic                tlast_q;

	always_comb begin
		if (pend_q != '0) begin
			sel = pend_q;
			kind_sel = kind_q;
			value_sel = value_q;
		end else begin
			sel = empty ? '0 : head.pend;
			kind_sel = head.kind;
			value_sel = head.value;
		end
		pick = sel & (~sel + PB_COUNT'(1));
		rem = sel & ~pick;
		tk_kind = TK_CLOSE;
		tk_value = '0;
		if (pick[PB_START]) begin
			tk_kind = TK_START;
		end else if (pick[PB_MAIN]) begin
			tk_kind = kind_sel;
			tk_value = value_sel;
		end else if (pick[PB_NL]) begin
			tk_kind = TK_NEWLINE;
		end else if (pick[PB_BOLD]) begin
			tk_value = {6'd0, STY_BOLD};
		end else if (pick[PB_UNDER]) begin
			tk_value = {6'd0, STY_UNDER};
		end else if (pick[PB_SUP]) begin
			tk_value = {6'd0, STY_SUP};
		end else begin
			tk_value = {6'd0, STY_SUB};
		end
	end

	assign advance = (sel != '0) && (!valid_q || tokens.ready);
	assign pop = advance && (pend_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pend_q <= rem;
				valid_q <= 1'b1;
			end else if (tokens.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			value_q <= head.value;
		end
		if (advance) begin
			tkind_q <= tk_kind;
			tvalue_q <= tk_value;
			tlast_q <= (rem == '0);
		end
	end

	assign tokens.valid = valid_q;
	assign tokens.token_kind = tkind_q;
	assign tokens.token_value = tvalue_q;
	assign tokens.last_token = tlast_q;

endmodule

/* hdl/wprm_checker.sv */
// Port-level checks of the converter's token channel, bound to the top level.
// Depends on wprm_pkg and word_processor_record_to_markup_unit.
module wprm_checker import wprm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [3:0] token_kind,
	input logic [7:0] token_value,
	input logic       last_token
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(token_kind) && $stable(token_value)
			&& $stable(last_token))
		else $error("token changed while stalled");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (token_kind == TK_END || token_kind == TK_ERROR) |-> last_token)
		else $error("end or error token not last");

	a_style: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (token_kind == TK_OPEN || token_kind == TK_CLOSE) |-> token_value < 8'd4)
		else $error("bad style code");

	a_spaces: assert property (@(posedge clk) disable iff (!arst_n)
		valid && token_kind == TK_SPACES |-> token_value != 8'd0)
		else $error("empty spaces token");

endmodule

bind word_processor_record_to_markup_unit wprm_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (tokens.valid),
	.ready       (tokens.ready),
	.token_kind  (tokens.token_kind),
	.token_value (tokens.token_value),
	.last_token  (tokens.last_token)
);
